>>> hdl/usb_descriptor_tree_parser_macros.svh
// assertion macros shared by the checker
`ifndef USB_DESCRIPTOR_TREE_PARSER_MACROS_SVH
`define USB_DESCRIPTOR_TREE_PARSER_MACROS_SVH

// same-cycle implication, gated by reset
`define UDTP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("udtp assertion failed");

// next-cycle implication, gated by reset
`define UDTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("udtp assertion failed");

`endif

>>> hdl/udtp_pkg.sv
package udtp_pkg;

    // request and result kinds
    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_FIND    = 1'b1;
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIND   = 1'b1;

    // descriptor types and lengths
    localparam logic [7:0] DESC_CONFIG    = 8'd2;
    localparam logic [7:0] DESC_INTERFACE = 8'd4;
    localparam logic [7:0] DESC_ENDPOINT  = 8'd5;
    localparam logic [7:0] LEN_CONFIG     = 8'd9;
    localparam logic [7:0] LEN_INTERFACE  = 8'd9;
    localparam logic [7:0] LEN_ENDPOINT   = 8'd7;

    // parse status codes
    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_ZERO_LEN = 3'd1,
        ERR_ORDER    = 3'd2,
        ERR_LENGTH   = 3'd3,
        ERR_LEFTOVER = 3'd4,
        ERR_CAPACITY = 3'd5
    } t_err;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [3:0] ep_number;
    } t_in_word;

    typedef struct packed {
        logic        result_kind;
        logic        parse_ok;
        logic [2:0]  error_code;
        logic        found;
        logic [3:0]  interface_index;
        logic [3:0]  endpoint_slot;
        logic [7:0]  endpoint_address;
        logic [7:0]  endpoint_attributes;
        logic [15:0] max_packet_size;
        logic [7:0]  poll_interval;
    } t_out_word;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_W_INIT,
        ST_W_LOOP,
        ST_W_FETCH,
        ST_W_CAP,
        ST_W_EVAL,
        ST_P_FIN,
        ST_F_INIT,
        ST_F_IF,
        ST_F_IFW,
        ST_F_SLOT,
        ST_F_EPW,
        ST_EMIT
    } t_state;

    // datapath operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_WALK_INIT,
        DP_WALK_CHECK,
        DP_FETCH,
        DP_CAPTURE,
        DP_EVAL,
        DP_PARSE_FIN,
        DP_FIND_INIT,
        DP_IF_READ,
        DP_IF_LATCH,
        DP_SLOT,
        DP_EP_CHECK,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic overflow;
        logic rem_more;
        logic cap_done;
        logic eval_fail;
        logic tree_valid;
        logic if_end;
        logic slot_end;
        logic slot_filled;
        logic want_zero;
        logic ep_match;
        logic out_free;
    } t_dp_status;

endpackage

>>> hdl/udtp_ram.sv
module udtp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/udtp_datapath.sv
module udtp_datapath import udtp_pkg::*; #(
    parameter int MAX_BYTES      = 1024,
    parameter int MAX_INTERFACES = 16,
    parameter int MAX_ENDPOINTS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_in_word   i_in_word,
    input  logic       i_out_stall,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_out_word  o_out_word
);

    localparam int RW = $clog2(MAX_BYTES + 1);
    localparam int BW = $clog2(MAX_BYTES);
    localparam int CW = (RW > 8) ? RW : 8;
    localparam int IW = $clog2(MAX_INTERFACES + 1);
    localparam int XW = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;
    localparam int EW = $clog2(MAX_ENDPOINTS + 1);
    localparam int SW = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
    localparam int TD = MAX_INTERFACES * MAX_ENDPOINTS;
    localparam int TW = (TD > 1) ? $clog2(TD) : 1;

    // control registers
    logic [RW-1:0]             r_byte_count, n_byte_count;
    logic                      r_overflow, n_overflow;
    logic [2:0]                r_off, n_off;
    logic                      r_tree_valid, n_tree_valid;
    logic                      r_cfg_seen, n_cfg_seen;
    logic                      r_have_config, n_have_config;
    logic                      r_have_if, n_have_if;
    logic [IW-1:0]             r_itot, n_itot;
    logic [IW-1:0]             r_if_next, n_if_next;
    logic [MAX_INTERFACES-1:0] r_if_valid, n_if_valid;
    logic [IW-1:0]             r_k, n_k;
    logic [EW-1:0]             r_s, n_s;
    logic                      r_out_valid, n_out_valid;
    t_err                      r_err, n_err;

    // payload registers
    logic [RW-1:0]             r_pos, n_pos;
    logic [RW-1:0]             r_rem, n_rem;
    logic [7:0]                r_desc [7];
    logic [7:0]                n_desc [7];
    logic [XW-1:0]             r_cur_if, n_cur_if;
    logic [EW-1:0]             r_cur_tot, n_cur_tot;
    logic [EW-1:0]             r_cur_fill, n_cur_fill;
    logic [3:0]                r_want, n_want;
    t_out_word                 r_res, n_res;
    t_out_word                 r_out_word, n_out_word;

    // memory ports
    logic                      byte_we;
    logic [BW-1:0]             byte_waddr, byte_raddr;
    logic [7:0]                byte_q;
    logic                      cnt_we;
    logic [XW-1:0]             cnt_waddr, cnt_raddr;
    logic [2*EW-1:0]           cnt_wdata, cnt_q;
    logic                      tbl_we;
    logic [TW-1:0]             tbl_waddr, tbl_raddr;
    logic [39:0]               tbl_wdata, tbl_q;

    t_err                      ev_code;
    logic                      out_free;

    udtp_ram #(.WIDTH(8), .DEPTH(MAX_BYTES)) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (byte_waddr),
        .i_wdata (i_in_word.data_byte),
        .i_raddr (byte_raddr),
        .o_rdata (byte_q)
    );

    udtp_ram #(.WIDTH(2 * EW), .DEPTH(MAX_INTERFACES)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_q)
    );

    udtp_ram #(.WIDTH(40), .DEPTH(TD)) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_q)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    // descriptor checks on the fetched bytes
    always_comb begin
        ev_code = ERR_NONE;
        if (r_desc[0] == 8'd0) begin
            ev_code = ERR_ZERO_LEN;
        end else if (CW'(r_desc[0]) > CW'(r_rem)) begin
            ev_code = ERR_LENGTH;
        end else begin
            case (r_desc[1])
                DESC_CONFIG: begin
                    if (!r_cfg_seen) begin
                        if (r_desc[0] != LEN_CONFIG) begin
                            ev_code = ERR_LENGTH;
                        end else if (r_desc[4] > 8'(MAX_INTERFACES)) begin
                            ev_code = ERR_CAPACITY;
                        end
                    end
                end
                DESC_INTERFACE: begin
                    if (!r_have_config) begin
                        ev_code = ERR_ORDER;
                    end else if (r_desc[0] != LEN_INTERFACE) begin
                        ev_code = ERR_LENGTH;
                    end else if (r_desc[2] != 8'(r_if_next)) begin
                        ev_code = ERR_ORDER;
                    end else if (r_if_next >= r_itot) begin
                        ev_code = ERR_CAPACITY;
                    end else if (r_desc[4] > 8'(MAX_ENDPOINTS)) begin
                        ev_code = ERR_CAPACITY;
                    end
                end
                DESC_ENDPOINT: begin
                    if (!r_have_config || !r_have_if) begin
                        ev_code = ERR_ORDER;
                    end else if (r_desc[0] != LEN_ENDPOINT) begin
                        ev_code = ERR_LENGTH;
                    end else if (r_cur_fill >= r_cur_tot) begin
                        ev_code = ERR_CAPACITY;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // status back to the controller
    always_comb begin
        o_status.overflow    = r_overflow;
        o_status.rem_more    = r_rem > RW'(2);
        o_status.cap_done    = r_off == 3'd6;
        o_status.eval_fail   = ev_code != ERR_NONE;
        o_status.tree_valid  = r_tree_valid;
        o_status.if_end      = r_k >= r_itot;
        o_status.slot_end    = r_s >= r_cur_tot;
        o_status.slot_filled = r_s < r_cur_fill;
        o_status.want_zero   = r_want == 4'd0;
        o_status.ep_match    = tbl_q[35:32] == r_want;
        o_status.out_free    = out_free;
    end

    // next values per command
    always_comb begin
        n_byte_count  = r_byte_count;
        n_overflow    = r_overflow;
        n_off         = r_off;
        n_tree_valid  = r_tree_valid;
        n_cfg_seen    = r_cfg_seen;
        n_have_config = r_have_config;
        n_have_if     = r_have_if;
        n_itot        = r_itot;
        n_if_next     = r_if_next;
        n_if_valid    = r_if_valid;
        n_k           = r_k;
        n_s           = r_s;
        n_out_valid   = r_out_valid && i_out_stall;
        n_err         = r_err;
        n_pos         = r_pos;
        n_rem         = r_rem;
        n_desc        = r_desc;
        n_cur_if      = r_cur_if;
        n_cur_tot     = r_cur_tot;
        n_cur_fill    = r_cur_fill;
        n_want        = r_want;
        n_res         = r_res;
        n_out_word    = r_out_word;

        byte_we    = 1'b0;
        byte_waddr = r_byte_count[BW-1:0];
        byte_raddr = BW'(r_pos + RW'(r_off));
        cnt_we     = 1'b0;
        cnt_waddr  = r_cur_if;
        cnt_wdata  = {r_cur_tot, r_cur_fill};
        cnt_raddr  = r_k[XW-1:0];
        tbl_we     = 1'b0;
        tbl_waddr  = TW'(int'(r_cur_if) * MAX_ENDPOINTS + int'(r_cur_fill[SW-1:0]));
        tbl_wdata  = {r_desc[2], r_desc[3], r_desc[5], r_desc[4], r_desc[6]};
        tbl_raddr  = TW'(int'(r_k[XW-1:0]) * MAX_ENDPOINTS + int'(r_s[SW-1:0]));

        case (i_cmd.op)
            // take a byte or a find request
            DP_ACCEPT: begin
                if (i_in_word.req_type == REQ_LOAD) begin
                    if (r_byte_count < RW'(MAX_BYTES)) begin
                        byte_we      = 1'b1;
                        n_byte_count = r_byte_count + RW'(1);
                    end else begin
                        n_overflow = 1'b1;
                    end
                end else begin
                    n_want = i_in_word.ep_number;
                end
            end
            // clear the tree and start at the buffer head
            DP_WALK_INIT: begin
                n_pos         = '0;
                n_rem         = r_byte_count;
                n_itot        = '0;
                n_cfg_seen    = 1'b0;
                n_have_config = 1'b0;
                n_have_if     = 1'b0;
                n_if_next     = '0;
                n_if_valid    = '0;
                n_cur_if      = '0;
                n_cur_tot     = '0;
                n_cur_fill    = '0;
                n_err         = r_overflow ? ERR_CAPACITY : ERR_NONE;
            end
            // walk end test
            DP_WALK_CHECK: begin
                n_off = 3'd0;
                if (r_rem <= RW'(2)) begin
                    n_err = (r_rem != '0) ? ERR_LEFTOVER : ERR_NONE;
                end
            end
            DP_FETCH: begin
            end
            DP_CAPTURE: begin
                n_desc[r_off] = byte_q;
                n_off         = r_off + 3'd1;
            end
            // apply one descriptor
            DP_EVAL: begin
                n_err = ev_code;
                if (ev_code == ERR_NONE) begin
                    n_pos = r_pos + RW'(r_desc[0]);
                    n_rem = r_rem - RW'(r_desc[0]);
                    case (r_desc[1])
                        DESC_CONFIG: begin
                            if (!r_cfg_seen) begin
                                n_itot        = IW'(r_desc[4]);
                                n_have_config = 1'b1;
                            end
                            n_cfg_seen = 1'b1;
                            n_if_next  = '0;
                        end
                        DESC_INTERFACE: begin
                            n_cur_if   = r_if_next[XW-1:0];
                            n_cur_tot  = EW'(r_desc[4]);
                            n_cur_fill = '0;
                            cnt_we     = 1'b1;
                            cnt_waddr  = r_if_next[XW-1:0];
                            cnt_wdata  = {EW'(r_desc[4]), {EW{1'b0}}};
                            n_if_valid[r_if_next[XW-1:0]] = 1'b1;
                            n_have_if  = 1'b1;
                            n_if_next  = r_if_next + IW'(1);
                        end
                        DESC_ENDPOINT: begin
                            tbl_we     = 1'b1;
                            n_cur_fill = r_cur_fill + EW'(1);
                            cnt_we     = 1'b1;
                            cnt_wdata  = {r_cur_tot, r_cur_fill + EW'(1)};
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // status word and buffer restart
            DP_PARSE_FIN: begin
                n_res             = '0;
                n_res.result_kind = KIND_STATUS;
                n_res.parse_ok    = r_err == ERR_NONE;
                n_res.error_code  = r_err;
                n_tree_valid      = r_err == ERR_NONE;
                n_byte_count      = '0;
                n_overflow        = 1'b0;
            end
            DP_FIND_INIT: begin
                n_res             = '0;
                n_res.result_kind = KIND_FIND;
                n_k               = '0;
            end
            DP_IF_READ: begin
            end
            // counts of interface k, empty if its valid bit is clear
            DP_IF_LATCH: begin
                if (r_if_valid[r_k[XW-1:0]]) begin
                    n_cur_tot  = cnt_q[2*EW-1:EW];
                    n_cur_fill = cnt_q[EW-1:0];
                end else begin
                    n_cur_tot  = '0;
                    n_cur_fill = '0;
                end
                n_s = '0;
            end
            // next slot: stored, declared-empty, or end of interface
            DP_SLOT: begin
                if (r_s >= r_cur_tot) begin
                    n_k = r_k + IW'(1);
                end else if (r_s < r_cur_fill) begin
                end else if (r_want == 4'd0) begin
                    n_res.found           = 1'b1;
                    n_res.interface_index = 4'(r_k);
                    n_res.endpoint_slot   = 4'(r_s);
                end else begin
                    n_s = r_s + EW'(1);
                end
            end
            DP_EP_CHECK: begin
                if (tbl_q[35:32] == r_want) begin
                    n_res.found               = 1'b1;
                    n_res.interface_index     = 4'(r_k);
                    n_res.endpoint_slot       = 4'(r_s);
                    n_res.endpoint_address    = tbl_q[39:32];
                    n_res.endpoint_attributes = tbl_q[31:24];
                    n_res.max_packet_size     = tbl_q[23:8];
                    n_res.poll_interval       = tbl_q[7:0];
                end else begin
                    n_s = r_s + EW'(1);
                end
            end
            DP_EMIT: begin
                n_out_valid = 1'b1;
                n_out_word  = r_res;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= '0;
            r_overflow    <= 1'b0;
            r_off         <= '0;
            r_tree_valid  <= 1'b0;
            r_cfg_seen    <= 1'b0;
            r_have_config <= 1'b0;
            r_have_if     <= 1'b0;
            r_itot        <= '0;
            r_if_next     <= '0;
            r_if_valid    <= '0;
            r_k           <= '0;
            r_s           <= '0;
            r_out_valid   <= 1'b0;
            r_err         <= ERR_NONE;
        end else begin
            r_byte_count  <= n_byte_count;
            r_overflow    <= n_overflow;
            r_off         <= n_off;
            r_tree_valid  <= n_tree_valid;
            r_cfg_seen    <= n_cfg_seen;
            r_have_config <= n_have_config;
            r_have_if     <= n_have_if;
            r_itot        <= n_itot;
            r_if_next     <= n_if_next;
            r_if_valid    <= n_if_valid;
            r_k           <= n_k;
            r_s           <= n_s;
            r_out_valid   <= n_out_valid;
            r_err         <= n_err;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_rem      <= n_rem;
        r_desc     <= n_desc;
        r_cur_if   <= n_cur_if;
        r_cur_tot  <= n_cur_tot;
        r_cur_fill <= n_cur_fill;
        r_want     <= n_want;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

>>> hdl/udtp_ctrl.sv
module udtp_ctrl import udtp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_word   i_in_word,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_word.req_type == REQ_FIND) begin
                        n_state = ST_F_INIT;
                    end else if (i_in_word.last_byte) begin
                        n_state = ST_W_INIT;
                    end
                end
            end
            ST_W_INIT:  n_state = i_status.overflow ? ST_P_FIN : ST_W_LOOP;
            ST_W_LOOP:  n_state = i_status.rem_more ? ST_W_FETCH : ST_P_FIN;
            ST_W_FETCH: n_state = ST_W_CAP;
            ST_W_CAP:   n_state = i_status.cap_done ? ST_W_EVAL : ST_W_FETCH;
            ST_W_EVAL:  n_state = i_status.eval_fail ? ST_P_FIN : ST_W_LOOP;
            ST_P_FIN:   n_state = ST_EMIT;
            ST_F_INIT:  n_state = i_status.tree_valid ? ST_F_IF : ST_EMIT;
            ST_F_IF:    n_state = i_status.if_end ? ST_EMIT : ST_F_IFW;
            ST_F_IFW:   n_state = ST_F_SLOT;
            ST_F_SLOT: begin
                if (i_status.slot_end) begin
                    n_state = ST_F_IF;
                end else if (i_status.slot_filled) begin
                    n_state = ST_F_EPW;
                end else if (i_status.want_zero) begin
                    n_state = ST_EMIT;
                end
            end
            ST_F_EPW:   n_state = i_status.ep_match ? ST_EMIT : ST_F_SLOT;
            ST_EMIT:    n_state = i_status.out_free ? ST_IDLE : ST_EMIT;
            default:    n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_in_stall = 1'b1;
        o_cmd.op   = DP_NOP;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.op   = i_in_valid ? DP_ACCEPT : DP_NOP;
            end
            ST_W_INIT:  o_cmd.op = DP_WALK_INIT;
            ST_W_LOOP:  o_cmd.op = DP_WALK_CHECK;
            ST_W_FETCH: o_cmd.op = DP_FETCH;
            ST_W_CAP:   o_cmd.op = DP_CAPTURE;
            ST_W_EVAL:  o_cmd.op = DP_EVAL;
            ST_P_FIN:   o_cmd.op = DP_PARSE_FIN;
            ST_F_INIT:  o_cmd.op = DP_FIND_INIT;
            ST_F_IF:    o_cmd.op = DP_IF_READ;
            ST_F_IFW:   o_cmd.op = DP_IF_LATCH;
            ST_F_SLOT:  o_cmd.op = DP_SLOT;
            ST_F_EPW:   o_cmd.op = DP_EP_CHECK;
            ST_EMIT:    o_cmd.op = i_status.out_free ? DP_EMIT : DP_NOP;
            default:    o_cmd.op = DP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/usb_descriptor_tree_parser.sv
// Configuration descriptor parser. Load words are stored in a byte memory
// while idle; the word that carries last_byte starts a walk that reads the
// buffer through that memory's registered read port, a fetch and a capture
// state per byte, seven bytes per descriptor plus a loop test and an
// evaluate state, before its status word is offered. A find walks the
// stored endpoint table in interface then slot order: a read, a latch and
// a slot state per declared interface, and per slot visited a slot state
// and, for a filled slot, an endpoint check, limited by the registered
// reads of the count and endpoint memories.
// The result register lets a new request in while a word waits on the
// output. Endpoint memories need no clearing pass: per-interface valid
// bits and fill counts mark what the current parse has written.
module usb_descriptor_tree_parser import udtp_pkg::*; #(
    parameter int MAX_BYTES      = 1024,
    parameter int MAX_INTERFACES = 16,
    parameter int MAX_ENDPOINTS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_dp_cmd    cmd;
    t_dp_status status;

    udtp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    udtp_datapath #(
        .MAX_BYTES      (MAX_BYTES),
        .MAX_INTERFACES (MAX_INTERFACES),
        .MAX_ENDPOINTS  (MAX_ENDPOINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

>>> hdl/udtp_checker.sv
`include "usb_descriptor_tree_parser_macros.svh"

module udtp_checker import udtp_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // a stalled word stays offered
    `UDTP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // an accepted find keeps the input busy while the table is searched
    `UDTP_ASSERT_NEXT(a_find_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_in_word.req_type == REQ_FIND), o_in_stall)

    // status words carry ok exactly when the code is clear, with no hit and no unused code
    `UDTP_ASSERT_NOW(a_status_ok, i_clk, i_rst_n, o_out_valid && !o_out_word.result_kind, (o_out_word.parse_ok == (o_out_word.error_code == ERR_NONE)) && !o_out_word.found && (o_out_word.error_code != 3'd6) && (o_out_word.error_code != 3'd7))

    // find answers carry no parse status
    `UDTP_ASSERT_NOW(a_find_clean, i_clk, i_rst_n, o_out_valid && o_out_word.result_kind, !o_out_word.parse_ok && (o_out_word.error_code == ERR_NONE))

    // a miss leaves interface index, slot, address and max packet size at zero
    `UDTP_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_out_word.found, (o_out_word.interface_index == 4'd0) && (o_out_word.endpoint_slot == 4'd0) && (o_out_word.endpoint_address == 8'd0) && (o_out_word.max_packet_size == 16'd0))

endmodule

bind usb_descriptor_tree_parser udtp_checker u_checker (.*);
